// ===== hw/rtl/lcs_pkg.sv =====
// Types, codes and constants shared by the level crossing sequencer files.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    localparam int unsigned ENTER_SENSORS = 8;
    localparam int unsigned LEAVE_SENSORS = 8;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SENSOR_W = 8;
    localparam int unsigned VOL_W    = 8;
    localparam int unsigned IVL_W    = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_OPEN  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_ENTERING    = 4'd1,
        PH_SOUND_START = 4'd2,
        PH_RAMP_UP     = 4'd3,
        PH_PLAYING     = 4'd4,
        PH_LEAVING     = 4'd5,
        PH_LEAVED      = 4'd6,
        PH_RAMP_DOWN   = 4'd7,
        PH_STOP        = 4'd8
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_VOLUME  = 2'd0,
        REG_MAX_VOLUME  = 2'd1,
        REG_VOLUME_STEP = 2'd2,
        REG_RAMP_IVL    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [VOL_W-1:0] min_volume;
        logic [VOL_W-1:0] max_volume;
        logic [VOL_W-1:0] volume_step;
        logic [IVL_W-1:0] ramp_interval_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd                command;
        logic [TIME_W-1:0]   now_ms;
        logic [SENSOR_W-1:0] enter_sensors;
        logic [SENSOR_W-1:0] leave_sensors;
    } t_item;

    typedef struct packed {
        t_phase           phase;
        logic [VOL_W-1:0] volume;
        logic             lights_on;
        logic             fences_closed;
        logic             sound_repeat;
        logic             sound_play_pulse;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/lcs_cfg.sv =====
// Configuration register bank of the level crossing sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcs_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lcs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output lcs_pkg::t_cfg                        o_cfg
);

    lcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_volume       <= 8'd0;
            r_cfg.max_volume       <= 8'd255;
            r_cfg.volume_step      <= 8'd8;
            r_cfg.ramp_interval_ms <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (lcs_pkg::t_cfg_idx'(i_cfg_index))
                lcs_pkg::REG_MIN_VOLUME: begin
                    r_cfg.min_volume <= i_cfg_wdata[lcs_pkg::VOL_W-1:0];
                end
                lcs_pkg::REG_MAX_VOLUME: begin
                    r_cfg.max_volume <= i_cfg_wdata[lcs_pkg::VOL_W-1:0];
                end
                lcs_pkg::REG_VOLUME_STEP: begin
                    r_cfg.volume_step <= i_cfg_wdata[lcs_pkg::VOL_W-1:0];
                end
                lcs_pkg::REG_RAMP_IVL: begin
                    r_cfg.ramp_interval_ms <= i_cfg_wdata[lcs_pkg::IVL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/lcs_core.sv =====
// Phase machine and sound, light and fence state of the level crossing sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcs_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire lcs_pkg::t_item i_item,
    input  wire lcs_pkg::t_cfg  i_cfg,
    output lcs_pkg::t_result o_result
);

    lcs_pkg::t_phase                 r_phase, n_phase;
    logic [lcs_pkg::VOL_W-1:0]       r_volume, n_volume;
    logic [lcs_pkg::TIME_W-1:0]      r_last_step, n_last_step;
    logic                            r_lights, n_lights;
    logic                            r_fences, n_fences;
    logic                            r_repeat, n_repeat;
    logic                            n_pulse;

    logic                            enter_any;
    logic                            leave_any;
    logic [lcs_pkg::TIME_W-1:0]      elapsed;
    logic                            step_due;
    logic [lcs_pkg::VOL_W:0]         vol_sum;
    logic                            up_done;
    logic [lcs_pkg::VOL_W:0]         down_bound;
    logic                            down_done;

    assign enter_any = |i_item.enter_sensors[lcs_pkg::ENTER_SENSORS-1:0];
    assign leave_any = |i_item.leave_sensors[lcs_pkg::LEAVE_SENSORS-1:0];
    assign elapsed   = i_item.now_ms - r_last_step;
    assign step_due  = elapsed > {{(lcs_pkg::TIME_W-lcs_pkg::IVL_W){1'b0}},
                                  i_cfg.ramp_interval_ms};
    assign vol_sum    = {1'b0, r_volume} + {1'b0, i_cfg.volume_step};
    assign up_done    = vol_sum >= {1'b0, i_cfg.max_volume};
    // Volume minus step at or below the minimum, rearranged to avoid a signed result.
    assign down_bound = {1'b0, i_cfg.min_volume} + {1'b0, i_cfg.volume_step};
    assign down_done  = {1'b0, r_volume} <= down_bound;

    always_comb begin
        n_phase = r_phase;
        unique case (i_item.command)
            lcs_pkg::CMD_CLOSE: n_phase = lcs_pkg::PH_ENTERING;
            lcs_pkg::CMD_OPEN:  n_phase = lcs_pkg::PH_LEAVED;
            lcs_pkg::CMD_POLL: begin
                unique case (r_phase)
                    lcs_pkg::PH_IDLE: begin
                        if (enter_any) n_phase = lcs_pkg::PH_ENTERING;
                    end
                    lcs_pkg::PH_ENTERING:    n_phase = lcs_pkg::PH_SOUND_START;
                    lcs_pkg::PH_SOUND_START: n_phase = lcs_pkg::PH_RAMP_UP;
                    lcs_pkg::PH_RAMP_UP: begin
                        if (step_due && up_done) n_phase = lcs_pkg::PH_PLAYING;
                    end
                    lcs_pkg::PH_PLAYING: begin
                        if (leave_any) n_phase = lcs_pkg::PH_LEAVING;
                    end
                    lcs_pkg::PH_LEAVING: begin
                        if (!leave_any) n_phase = lcs_pkg::PH_LEAVED;
                    end
                    lcs_pkg::PH_LEAVED: n_phase = lcs_pkg::PH_RAMP_DOWN;
                    lcs_pkg::PH_RAMP_DOWN: begin
                        if (step_due && down_done) n_phase = lcs_pkg::PH_STOP;
                    end
                    lcs_pkg::PH_STOP: n_phase = lcs_pkg::PH_IDLE;
                    default: n_phase = r_phase;
                endcase
            end
            default: n_phase = r_phase;
        endcase
    end

    always_comb begin
        n_volume    = r_volume;
        n_last_step = r_last_step;
        n_lights    = r_lights;
        n_fences    = r_fences;
        n_repeat    = r_repeat;
        n_pulse     = 1'b0;
        if (i_item.command == lcs_pkg::CMD_POLL) begin
            unique case (r_phase)
                lcs_pkg::PH_ENTERING: n_lights = 1'b1;
                lcs_pkg::PH_SOUND_START: begin
                    n_repeat    = 1'b1;
                    n_pulse     = 1'b1;
                    n_volume    = i_cfg.min_volume;
                    n_last_step = i_item.now_ms;
                end
                lcs_pkg::PH_RAMP_UP: begin
                    n_repeat = 1'b1;
                    if (step_due) begin
                        n_last_step = i_item.now_ms;
                        if (up_done) begin
                            n_volume = i_cfg.max_volume;
                            n_fences = 1'b1;
                        end else begin
                            n_volume = vol_sum[lcs_pkg::VOL_W-1:0];
                        end
                    end
                end
                lcs_pkg::PH_PLAYING, lcs_pkg::PH_LEAVING, lcs_pkg::PH_LEAVED: begin
                    n_repeat = 1'b1;
                end
                lcs_pkg::PH_RAMP_DOWN: begin
                    n_repeat = 1'b1;
                    if (step_due) begin
                        n_last_step = i_item.now_ms;
                        if (down_done) begin
                            n_volume = i_cfg.min_volume;
                        end else begin
                            n_volume = r_volume - i_cfg.volume_step;
                        end
                    end
                end
                lcs_pkg::PH_STOP: begin
                    n_repeat = 1'b0;
                    n_fences = 1'b0;
                    n_lights = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcs_pkg::PH_IDLE;
            r_volume    <= '0;
            r_last_step <= '0;
            r_lights    <= 1'b0;
            r_fences    <= 1'b0;
            r_repeat    <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_volume    <= n_volume;
            r_last_step <= n_last_step;
            r_lights    <= n_lights;
            r_fences    <= n_fences;
            r_repeat    <= n_repeat;
        end
    end

    always_comb begin
        o_result.phase            = n_phase;
        o_result.volume           = n_volume;
        o_result.lights_on        = n_lights;
        o_result.fences_closed    = n_fences;
        o_result.sound_repeat     = n_repeat;
        o_result.sound_play_pulse = n_pulse;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/level_crossing_sequencer.sv =====
// Top level of the level crossing sequencer with stream ports and configuration port.
// Usage:
// Each transfer on the slave stream is one tick of the crossing controller: tuser
// carries the command (poll, force close, force open) and tdata the millisecond
// time and the enter and leave sensor vectors. Every transfer produces exactly one
// result transfer on the master stream with the phase, volume and output flags as
// they stand after that tick.
// A transfer is held in an input register and processed when the output register is
// free or its result is being taken; the new result is then loaded into the output
// register, from which the receiver takes it.
// One transfer per cycle is sustained while the receiver takes results, as the phase
// and volume registers update for every processed transfer.
// When the receiver stalls, the result stays in the output register and one further
// transfer is taken into the input register; tready then falls until the stall ends.
// Reset clears both stages, sets idle phase, volume 0, lights off, fences open, sound
// loop off, and loads the default configuration. Configuration writes take effect
// at once and are meant for periods when no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none

module level_crossing_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // now_ms [31:0], enter_sensors [39:32], leave_sensors [47:40]
    input  wire logic [lcs_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // command [1:0]
    input  wire logic [lcs_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // phase [3:0], volume [11:4], lights_on [12], fences_closed [13],
    // sound_repeat [14], sound_play_pulse [15]
    output logic [lcs_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lcs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    lcs_pkg::t_cfg    cfg;
    lcs_pkg::t_item   r_item;
    lcs_pkg::t_result result;
    lcs_pkg::t_result r_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             fire;
    logic             in_accept;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign in_accept  = i_s_tvalid && o_s_tready;

    lcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.command       <= lcs_pkg::t_cmd'(i_s_tuser);
            r_item.now_ms        <= i_s_tdata[31:0];
            r_item.enter_sensors <= i_s_tdata[39:32];
            r_item.leave_sensors <= i_s_tdata[47:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_result.sound_play_pulse, r_result.sound_repeat,
                         r_result.fences_closed, r_result.lights_on,
                         r_result.volume, r_result.phase};

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the level crossing sequencer, with its own phase predictor.
`timescale 1ns / 1ps

module tb;
    import lcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_GAP     = 6;
    localparam int unsigned REPORT_MAX  = 10;
    localparam logic [SENSOR_W-1:0] ENTER_MASK = SENSOR_W'((1 << ENTER_SENSORS) - 1);
    localparam logic [SENSOR_W-1:0] LEAVE_MASK = SENSOR_W'((1 << LEAVE_SENSORS) - 1);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [CMD_W-1:0]      i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    level_crossing_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_phase            ph_q;
    logic [VOL_W-1:0]  vol_q;
    logic [TIME_W-1:0] stamp_q;
    logic              lights_q;
    logic              fences_q;
    logic              loop_q;

    logic [VOL_W-1:0]  min_vol;
    logic [VOL_W-1:0]  max_vol;
    logic [VOL_W-1:0]  vol_step;
    logic [IVL_W-1:0]  ramp_ivl;

    t_result           crossing_states_q[$];
    int unsigned       fails;
    int unsigned       cycles;
    int unsigned       hold_off;
    bit                quiet;
    logic [TIME_W-1:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result crossing_next(t_item it);
        t_result           r;
        logic [VOL_W:0]    sum;
        int                diff;
        logic [TIME_W-1:0] elapsed;
        logic              due;
        elapsed = it.now_ms - stamp_q;
        due = elapsed > TIME_W'(ramp_ivl);
        r.sound_play_pulse = 1'b0;
        case (it.command)
            CMD_CLOSE: ph_q = PH_ENTERING;
            CMD_OPEN: ph_q = PH_LEAVED;
            CMD_POLL: begin
                case (ph_q)
                    PH_IDLE: begin
                        if ((it.enter_sensors & ENTER_MASK) != '0) ph_q = PH_ENTERING;
                    end
                    PH_ENTERING: begin
                        lights_q = 1'b1;
                        ph_q = PH_SOUND_START;
                    end
                    PH_SOUND_START: begin
                        loop_q = 1'b1;
                        r.sound_play_pulse = 1'b1;
                        vol_q = min_vol;
                        stamp_q = it.now_ms;
                        ph_q = PH_RAMP_UP;
                    end
                    PH_RAMP_UP: begin
                        loop_q = 1'b1;
                        if (due) begin
                            sum = {1'b0, vol_q} + {1'b0, vol_step};
                            stamp_q = it.now_ms;
                            if (sum >= {1'b0, max_vol}) begin
                                vol_q = max_vol;
                                fences_q = 1'b1;
                                ph_q = PH_PLAYING;
                            end else begin
                                vol_q = sum[VOL_W-1:0];
                            end
                        end
                    end
                    PH_PLAYING: begin
                        loop_q = 1'b1;
                        if ((it.leave_sensors & LEAVE_MASK) != '0) ph_q = PH_LEAVING;
                    end
                    PH_LEAVING: begin
                        loop_q = 1'b1;
                        if ((it.leave_sensors & LEAVE_MASK) == '0) ph_q = PH_LEAVED;
                    end
                    PH_LEAVED: begin
                        loop_q = 1'b1;
                        ph_q = PH_RAMP_DOWN;
                    end
                    PH_RAMP_DOWN: begin
                        loop_q = 1'b1;
                        if (due) begin
                            diff = int'(vol_q) - int'(vol_step);
                            stamp_q = it.now_ms;
                            if (diff <= int'(min_vol)) begin
                                vol_q = min_vol;
                                ph_q = PH_STOP;
                            end else begin
                                vol_q = VOL_W'(diff);
                            end
                        end
                    end
                    PH_STOP: begin
                        loop_q = 1'b0;
                        fences_q = 1'b0;
                        lights_q = 1'b0;
                        ph_q = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.phase = ph_q;
        r.volume = vol_q;
        r.lights_on = lights_q;
        r.fences_closed = fences_q;
        r.sound_repeat = loop_q;
        return r;
    endfunction

    task automatic note_failure(string what, t_result want, t_result got);
        fails++;
        if (fails <= REPORT_MAX) begin
            $display("%0t %s: expected phase %0d volume %0d lights %b fences %b loop %b pulse %b",
                     $time, what, want.phase, want.volume, want.lights_on,
                     want.fences_closed, want.sound_repeat, want.sound_play_pulse);
            $display("%0t %s: got      phase %0d volume %0d lights %b fences %b loop %b pulse %b",
                     $time, what, got.phase, got.volume, got.lights_on,
                     got.fences_closed, got.sound_repeat, got.sound_play_pulse);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.phase = t_phase'(o_m_tdata[3:0]);
            got.volume = o_m_tdata[11:4];
            got.lights_on = o_m_tdata[12];
            got.fences_closed = o_m_tdata[13];
            got.sound_repeat = o_m_tdata[14];
            got.sound_play_pulse = o_m_tdata[15];
            hold_off = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (crossing_states_q.size() == 0) begin
                note_failure("result with nothing outstanding", got, got);
            end else begin
                want = crossing_states_q.pop_front();
                if (got.phase !== want.phase || got.volume !== want.volume ||
                    got.lights_on !== want.lights_on ||
                    got.fences_closed !== want.fences_closed ||
                    got.sound_repeat !== want.sound_repeat ||
                    got.sound_play_pulse !== want.sound_play_pulse) begin
                    note_failure("result mismatch", want, got);
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_m_tready <= 1'b0;
                hold_off--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(t_cmd cmd, logic [TIME_W-1:0] now,
                             logic [SENSOR_W-1:0] enter, logic [SENSOR_W-1:0] leave);
        t_item       it;
        int unsigned gap;
        it.command = cmd;
        it.now_ms = now;
        it.enter_sensors = enter;
        it.leave_sensors = leave;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {leave, enter, now};
        do @(posedge i_clk); while (!o_s_tready);
        crossing_states_q.push_back(crossing_next(it));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (crossing_states_q.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_MIN_VOLUME: min_vol = value[VOL_W-1:0];
            REG_MAX_VOLUME: max_vol = value[VOL_W-1:0];
            REG_VOLUME_STEP: vol_step = value[VOL_W-1:0];
            REG_RAMP_IVL: ramp_ivl = value[IVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int unsigned lo, int unsigned hi, int unsigned step,
                                 int unsigned ivl);
        wait_drained();
        write_reg(REG_MIN_VOLUME, CFG_DATA_W'(lo));
        write_reg(REG_MAX_VOLUME, CFG_DATA_W'(hi));
        write_reg(REG_VOLUME_STEP, CFG_DATA_W'(step));
        write_reg(REG_RAMP_IVL, CFG_DATA_W'(ivl));
    endtask

    function automatic logic [SENSOR_W-1:0] train_pattern();
        if ($urandom_range(0, 1) == 0) return SENSOR_W'(1) << $urandom_range(0, SENSOR_W - 1);
        return SENSOR_W'($urandom_range(1, 255));
    endfunction

    task automatic run_traffic(int unsigned count, bit burst);
        int unsigned         n;
        int unsigned         pick;
        int unsigned         ivl;
        t_cmd                cmd;
        logic [SENSOR_W-1:0] enter;
        logic [SENSOR_W-1:0] leave;
        ivl = int'(ramp_ivl);
        clock_ms = $urandom;
        for (n = 0; n < count; n++) begin
            if (n % 50 == 0) quiet = burst || ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 90) cmd = CMD_POLL;
            else if (pick < 94) cmd = CMD_CLOSE;
            else if (pick < 98) cmd = CMD_OPEN;
            else cmd = CMD_NONE;
            case ($urandom_range(0, 5))
                0: ;
                1: clock_ms += $urandom_range(0, ivl);
                2: clock_ms += ivl;
                3: clock_ms += ivl + 1;
                4: clock_ms += $urandom_range(ivl + 1, 2 * ivl + 2);
                default: begin
                    if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
                    else clock_ms += ivl + 1 + $urandom_range(0, 3);
                end
            endcase
            if (ph_q == PH_IDLE) enter = ($urandom_range(0, 3) == 0) ? train_pattern() : '0;
            else enter = ($urandom_range(0, 1) == 0) ? SENSOR_W'($urandom_range(0, 255)) : '0;
            case (ph_q)
                PH_PLAYING: leave = ($urandom_range(0, 2) == 0) ? train_pattern() : '0;
                PH_LEAVING: leave = ($urandom_range(0, 1) == 0) ? train_pattern() : '0;
                default: leave = ($urandom_range(0, 1) == 0) ? SENSOR_W'($urandom_range(0, 255)) : '0;
            endcase
            send_tick(cmd, clock_ms, enter, leave);
        end
        quiet = 1'b0;
    endtask

    // A whole crossing cycle with a ramp that takes two steps each way, time wrapping
    // inside the upward ramp, ignored codes, and forced close and open.
    task automatic test_directed();
        apply_setting(0, 255, 128, 0);
        send_tick(CMD_POLL, 32'd100, 8'h00, 8'h00);
        send_tick(CMD_NONE, 32'd100, 8'hFF, 8'hFF);
        send_tick(CMD_POLL, 32'd100, 8'h80, 8'h00);
        send_tick(CMD_POLL, 32'd100, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd0, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd1, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd2, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd2, 8'h00, 8'h01);
        send_tick(CMD_POLL, 32'd3, 8'h00, 8'h80);
        send_tick(CMD_POLL, 32'd3, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd3, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd4, 8'h00, 8'h00);
        send_tick(CMD_NONE, 32'd5, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd5, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd6, 8'h00, 8'h00);
        send_tick(CMD_CLOSE, 32'd7, 8'hFF, 8'h00);
        send_tick(CMD_OPEN, 32'd7, 8'h00, 8'hFF);
        send_tick(CMD_POLL, 32'd8, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd9, 8'h00, 8'h00);
        send_tick(CMD_POLL, 32'd9, 8'h00, 8'h00);
    endtask

    task automatic test_default_ramp();
        apply_setting(0, 255, 8, 100);
        run_traffic(350, 1'b0);
    endtask

    task automatic test_fine_ramp();
        apply_setting(0, 255, 1, 0);
        run_traffic(350, 1'b0);
    endtask

    task automatic test_slow_interval();
        apply_setting(17, 255, 255, 65535);
        run_traffic(200, 1'b0);
    endtask

    // With no step the ramp only ends when the start volume already meets the bound;
    // otherwise only a forced command gets the sequence out of the ramp.
    task automatic test_zero_step();
        apply_setting(0, 0, 0, 1);
        run_traffic(60, 1'b0);
        apply_setting(10, 200, 0, 2);
        run_traffic(150, 1'b0);
    endtask

    task automatic test_inverted_bounds();
        apply_setting(255, 0, 30, 5);
        run_traffic(150, 1'b0);
    endtask

    task automatic test_back_to_back();
        apply_setting(100, 180, 7, 3);
        run_traffic(250, 1'b1);
    endtask

    initial begin
        int unsigned w;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = CMD_POLL;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MIN_VOLUME;
        i_cfg_wdata = '0;
        fails = 0;
        cycles = 0;
        hold_off = 0;
        quiet = 1'b0;
        clock_ms = '0;
        ph_q = PH_IDLE;
        vol_q = '0;
        stamp_q = '0;
        lights_q = 1'b0;
        fences_q = 1'b0;
        loop_q = 1'b0;
        min_vol = 8'd0;
        max_vol = 8'd255;
        vol_step = 8'd8;
        ramp_ivl = 16'd100;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_default_ramp();
        test_fine_ramp();
        test_slow_interval();
        test_zero_step();
        test_inverted_bounds();
        test_back_to_back();

        i_s_tvalid <= 1'b0;
        for (w = 0; w < 2000 && crossing_states_q.size() > 0; w++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        fails += crossing_states_q.size();
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
